// ----- rtl/sbft_pkg.sv -----
// Package for the sorted best-fit table: request/response structs,
// operation and status codes. No dependencies.
package sbft_pkg;

  typedef enum logic [1:0] {
    MODE_INSERT = 2'd0,
    MODE_REMOVE = 2'd1,
    MODE_QUERY  = 2'd2,
    MODE_NOP    = 2'd3
  } mode_e;

  typedef enum logic [1:0] {
    ST_OK   = 2'd0,
    ST_FULL = 2'd1,
    ST_NONE = 2'd2,
    ST_DUP  = 2'd3
  } status_e;

  localparam int unsigned IdBits  = 6;
  localparam int unsigned KeyBits = 32;

  typedef struct packed {
    logic [1:0]         mode;
    logic [IdBits-1:0]  node_id;
    logic [KeyBits-1:0] key_weight;
    logic               exact;
  } req_t;

  typedef struct packed {
    logic [1:0]         status;
    logic [IdBits-1:0]  found_id;
    logic [KeyBits-1:0] found_weight;
  } rsp_t;

endpackage

// ----- rtl/sbft_ram.sv -----
// Entry store of the sorted best-fit table: one write port, one read
// port, registered read data. Depends on nothing.
module sbft_ram #(
  parameter int unsigned Depth = 64,
  parameter int unsigned Width = 38,
  parameter int unsigned AddrBits = 6
) (
  input  logic                clk_i,
  input  logic                we_i,
  input  logic [AddrBits-1:0] waddr_i,
  input  logic [Width-1:0]    wdata_i,
  input  logic                re_i,
  input  logic [AddrBits-1:0] raddr_i,
  output logic [Width-1:0]    rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ----- rtl/sorted_best_fit_table.sv -----
// Sorted best-fit table, top level: request sequencer around the entry store.
// Depends on sbft_pkg and sbft_ram.
//
// Scans read the entry store through its single read port, one entry per cycle:
// an insert scans for the id, then walks down from the top to the insert
// position; remove and query scan the held entries. One request at a time; a
// response may wait in the output register while the next request is taken.
// Reset (async, active low) empties the table at once; entry contents are left
// as they are and only entries below the count are ever read.
module sorted_best_fit_table
  import sbft_pkg::*;
#(
  parameter int unsigned CAPACITY    = 64,
  parameter int unsigned WEIGHT_BITS = 32
) (
  input  logic clk_i,
  input  logic rst_ni,
  input  logic in_valid_i,
  output logic in_ready_o,
  input  req_t in_req_i,
  output logic out_valid_o,
  input  logic out_ready_i,
  output rsp_t out_rsp_o
);

  // Weights wider than the key field never carry more than the key's bits.
  localparam int unsigned WB = (WEIGHT_BITS > KeyBits) ? KeyBits : WEIGHT_BITS;
  localparam int unsigned IW = (CAPACITY > 1) ? $clog2(CAPACITY) : 1;
  localparam int unsigned CW = $clog2(CAPACITY + 1);
  localparam int unsigned EW = IdBits + WB;

  // One-hot sequencer states.
  typedef enum logic [5:0] {
    S_IDLE   = 6'b000001,
    S_DUP    = 6'b000010, // insert, pass 1: look for the id
    S_SHIFT  = 6'b000100, // insert, pass 2: walk down, shift up, drop in
    S_REMOVE = 6'b001000, // find the id, then pull later entries down
    S_QUERY  = 6'b010000,
    S_EMIT   = 6'b100000
  } state_e;

  state_e state_q, state_d;
  logic [CW-1:0] cnt_q, cnt_d;     // entry count
  logic [CW-1:0] ptr_q, ptr_d;     // scan pointer
  logic          rv_q, rv_d;       // read data in flight is valid
  logic [CW-1:0] ridx_q, ridx_d;   // index of the read data
  logic          found_q, found_d;
  logic          have_q, have_d;
  logic          out_valid_q, out_valid_d;

  // Request fields held for the whole operation.
  logic [IdBits-1:0] op_id_q;
  logic [WB-1:0]     op_w_q;
  logic              op_exact_q;

  logic [WB-1:0]     bd_q, bd_d;
  logic [IdBits-1:0] best_id_q, best_id_d;
  logic [WB-1:0]     best_w_q, best_w_d;
  rsp_t              res_q, res_d;
  rsp_t              out_q, out_d;

  // Store ports.
  logic          we, re;
  logic [IW-1:0] waddr, raddr;
  logic [EW-1:0] wdata, rdata;
  logic [IdBits-1:0] rd_id;
  logic [WB-1:0]     rd_w;

  sbft_ram #(
    .Depth   (CAPACITY),
    .Width   (EW),
    .AddrBits(IW)
  ) u_ram (
    .clk_i  (clk_i),
    .we_i   (we),
    .waddr_i(waddr),
    .wdata_i(wdata),
    .re_i   (re),
    .raddr_i(raddr),
    .rdata_o(rdata)
  );

  assign rd_id = rdata[EW-1:WB];
  assign rd_w  = rdata[WB-1:0];

  // Weight compare and distance, shared by the insert walk and both queries.
  logic [WB:0]   sub_ab;
  logic [WB-1:0] sub_ba, wdist;
  logic          lt;
  assign sub_ab = {1'b0, rd_w} - {1'b0, op_w_q};
  assign sub_ba = op_w_q - rd_w;
  assign lt     = sub_ab[WB];
  assign wdist  = lt ? sub_ba : sub_ab[WB-1:0];

  logic          accept, fwd_more, bwd_more, scan_end;
  logic [CW-1:0] ptr_m1, ridx_p1, ridx_m1;
  logic [EW-1:0] new_entry;

  assign accept    = in_valid_i && in_ready_o;
  assign fwd_more  = ptr_q < cnt_q;
  assign bwd_more  = ptr_q != '0;
  assign scan_end  = !rv_q && !fwd_more;
  assign ptr_m1    = ptr_q - CW'(1);
  assign ridx_p1   = ridx_q + CW'(1);
  assign ridx_m1   = ridx_q - CW'(1);
  assign new_entry = {op_id_q, op_w_q};

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    ptr_d       = ptr_q;
    rv_d        = 1'b0;
    ridx_d      = ridx_q;
    found_d     = found_q;
    have_d      = have_q;
    bd_d        = bd_q;
    best_id_d   = best_id_q;
    best_w_d    = best_w_q;
    res_d       = res_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !out_ready_i;
    we          = 1'b0;
    waddr       = '0;
    wdata       = '0;
    re          = 1'b0;
    raddr       = '0;

    // Forward scans keep one read in flight ahead of the data being looked at.
    if ((state_q inside {S_DUP, S_REMOVE, S_QUERY}) && fwd_more) begin
      re     = 1'b1;
      raddr  = ptr_q[IW-1:0];
      ptr_d  = ptr_q + CW'(1);
      rv_d   = 1'b1;
      ridx_d = ptr_q;
    end
    if (state_q == S_SHIFT && bwd_more) begin
      re     = 1'b1;
      raddr  = ptr_m1[IW-1:0];
      ptr_d  = ptr_m1;
      rv_d   = 1'b1;
      ridx_d = ptr_m1;
    end

    case (state_q)
      S_IDLE: begin
        if (accept) begin
          ptr_d   = '0;
          rv_d    = 1'b0;
          found_d = 1'b0;
          have_d  = 1'b0;
          case (in_req_i.mode)
            MODE_INSERT: state_d = S_DUP;
            MODE_REMOVE: state_d = S_REMOVE;
            MODE_QUERY:  state_d = S_QUERY;
            default: begin
              res_d   = '{status: ST_OK, found_id: '0, found_weight: '0};
              state_d = S_EMIT;
            end
          endcase
        end
      end
      S_DUP: begin
        if (rv_q && rd_id == op_id_q) begin
          res_d   = '{status: ST_DUP, found_id: '0, found_weight: '0};
          state_d = S_EMIT;
        end else if (scan_end) begin
          if (cnt_q >= CW'(CAPACITY)) begin
            res_d   = '{status: ST_FULL, found_id: '0, found_weight: '0};
            state_d = S_EMIT;
          end else begin
            ptr_d   = cnt_q;
            rv_d    = 1'b0;
            state_d = S_SHIFT;
          end
        end
      end
      S_SHIFT: begin
        // Entries at or above the new weight move up one slot; the new
        // entry lands just above the first lighter one, or at the bottom.
        if (rv_q) begin
          we    = 1'b1;
          waddr = ridx_p1[IW-1:0];
          if (!lt) begin
            wdata = rdata;
          end else begin
            wdata   = new_entry;
            cnt_d   = cnt_q + CW'(1);
            res_d   = '{status: ST_OK, found_id: '0, found_weight: '0};
            state_d = S_EMIT;
          end
        end else if (!bwd_more) begin
          we      = 1'b1;
          waddr   = '0;
          wdata   = new_entry;
          cnt_d   = cnt_q + CW'(1);
          res_d   = '{status: ST_OK, found_id: '0, found_weight: '0};
          state_d = S_EMIT;
        end
      end
      S_REMOVE: begin
        if (rv_q) begin
          if (found_q) begin
            we    = 1'b1;
            waddr = ridx_m1[IW-1:0];
            wdata = rdata;
          end else if (rd_id == op_id_q) begin
            found_d = 1'b1;
          end
        end
        if (scan_end) begin
          if (found_q) begin
            cnt_d = cnt_q - CW'(1);
            res_d = '{status: ST_OK, found_id: '0, found_weight: '0};
          end else begin
            res_d = '{status: ST_NONE, found_id: '0, found_weight: '0};
          end
          state_d = S_EMIT;
        end
      end
      S_QUERY: begin
        if (rv_q) begin
          if (op_exact_q) begin
            if (!lt) begin
              res_d   = '{status: ST_OK, found_id: rd_id, found_weight: KeyBits'(rd_w)};
              state_d = S_EMIT;
            end
          end else if (!have_q || wdist <= bd_q) begin
            // Equal distance: the later entry wins.
            have_d    = 1'b1;
            bd_d      = wdist;
            best_id_d = rd_id;
            best_w_d  = rd_w;
          end
        end
        if (scan_end) begin
          if (!op_exact_q && have_q) begin
            res_d = '{status: ST_OK, found_id: best_id_q,
                      found_weight: KeyBits'(best_w_q)};
          end else begin
            res_d = '{status: ST_NONE, found_id: '0, found_weight: '0};
          end
          state_d = S_EMIT;
        end
      end
      S_EMIT: begin
        if (!out_valid_q || out_ready_i) begin
          out_d       = res_q;
          out_valid_d = 1'b1;
          state_d     = S_IDLE;
        end
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= S_IDLE;
      cnt_q       <= '0;
      rv_q        <= 1'b0;
      found_q     <= 1'b0;
      have_q      <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      rv_q        <= rv_d;
      found_q     <= found_d;
      have_q      <= have_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    ptr_q     <= ptr_d;
    ridx_q    <= ridx_d;
    bd_q      <= bd_d;
    best_id_q <= best_id_d;
    best_w_q  <= best_w_d;
    res_q     <= res_d;
    out_q     <= out_d;
    if (accept) begin
      op_id_q    <= in_req_i.node_id;
      op_w_q     <= in_req_i.key_weight[WB-1:0];
      op_exact_q <= in_req_i.exact;
    end
  end

  assign in_ready_o  = state_q == S_IDLE;
  assign out_valid_o = out_valid_q;
  assign out_rsp_o   = out_q;

  // Count never exceeds the table size.
  a_cnt_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cnt_q <= CW'(CAPACITY))
    else $error("entry count above capacity");

  // Only the insert walk and the remove scan change the count.
  a_cnt_owner: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !$stable(cnt_q) |-> ($past(state_q) == S_SHIFT || $past(state_q) == S_REMOVE))
    else $error("entry count changed outside insert or remove");

  // Writes stay within the occupied region plus the slot being filled.
  a_wr_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    we |-> (CW'(waddr) <= cnt_q && (state_q == S_SHIFT || state_q == S_REMOVE)))
    else $error("store write outside occupied range or state");

  // A response is loaded only when the output register is free.
  a_no_overwrite: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == S_EMIT && out_valid_q && !out_ready_i) |=> state_q == S_EMIT)
    else $error("response left while output register busy");

endmodule

// ----- tb/tb_sorted_best_fit_table.sv -----
// Self-checking bench for sorted_best_fit_table: a directed run, then ~1000
// random insert/remove/query requests, scored against an in-bench table model.
// Depends on sbft_pkg and the sorted_best_fit_table RTL.
module tb_sorted_best_fit_table;
  import sbft_pkg::*;

  localparam int unsigned TableDepth   = 64;
  localparam int unsigned RandomItems  = 1000;
  localparam int unsigned SettleCycles = 200;
  localparam int unsigned CycleLimit   = 1000000;

  // Shape of the random traffic: grow the table, shrink it, or churn.
  typedef enum int unsigned {PH_FILL, PH_DRAIN, PH_MIX} traffic_phase_e;

  // One planned request: payload, idle cycles in front, and whether the
  // sender first waits for every outstanding response.
  typedef struct {
    req_t        req;
    int unsigned gap;
    bit          drain;
  } planned_req_t;

  logic clk_i       = 1'b0;
  logic rst_ni      = 1'b0;
  logic in_valid_i  = 1'b0;
  logic in_ready_o;
  req_t in_req_i    = '0;
  logic out_valid_o;
  logic out_ready_i = 1'b0;
  rsp_t out_rsp_o;

  sorted_best_fit_table #(
    .CAPACITY    (TableDepth),
    .WEIGHT_BITS (KeyBits)
  ) i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .in_valid_i  (in_valid_i),
    .in_ready_o  (in_ready_o),
    .in_req_i    (in_req_i),
    .out_valid_o (out_valid_o),
    .out_ready_i (out_ready_i),
    .out_rsp_o   (out_rsp_o)
  );

  initial begin
    forever #4 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------------------
  // Table model. Entries sorted by ascending weight; updated once per request
  // taken by the block, in acceptance order.
  // ---------------------------------------------------------------------------
  logic [KeyBits-1:0] tbl_weight [TableDepth];
  logic [IdBits-1:0]  tbl_id     [TableDepth];
  int unsigned        tbl_fill = 0;

  // Run statistics for the closing summary.
  int unsigned op_cnt [4];
  int unsigned status_cnt [4];
  int unsigned peak_fill = 0;

  function automatic rsp_t apply_table_op(req_t r);
    rsp_t               rsp;
    int                 hit;
    int                 pos;
    int                 i;
    int                 best;
    bit                 have;
    logic [KeyBits-1:0] w;
    logic [KeyBits-1:0] d;
    logic [KeyBits-1:0] best_d;
    rsp    = '0;
    w      = r.key_weight;
    hit    = -1;
    best   = 0;
    have   = 1'b0;
    best_d = '0;
    for (i = 0; i < int'(tbl_fill); i++) begin
      if (hit < 0 && tbl_id[i] == r.node_id) hit = i;
    end
    case (r.mode)
      MODE_INSERT: begin
        // duplicate id wins over a full table
        if (hit >= 0) begin
          rsp.status = ST_DUP;
        end else if (tbl_fill >= TableDepth) begin
          rsp.status = ST_FULL;
        end else begin
          // new entry lands in front of any equal weight
          pos = 0;
          while (pos < int'(tbl_fill) && tbl_weight[pos] < w) pos++;
          for (i = int'(tbl_fill); i > pos; i--) begin
            tbl_weight[i] = tbl_weight[i-1];
            tbl_id[i]     = tbl_id[i-1];
          end
          tbl_weight[pos] = w;
          tbl_id[pos]     = r.node_id;
          tbl_fill++;
        end
      end
      MODE_REMOVE: begin
        if (hit < 0) begin
          rsp.status = ST_NONE;
        end else begin
          for (i = hit; i + 1 < int'(tbl_fill); i++) begin
            tbl_weight[i] = tbl_weight[i+1];
            tbl_id[i]     = tbl_id[i+1];
          end
          tbl_fill--;
        end
      end
      MODE_QUERY: begin
        if (r.exact) begin
          // first entry at or above the search weight
          for (i = 0; i < int'(tbl_fill); i++) begin
            if (!have && tbl_weight[i] >= w) begin
              best = i;
              have = 1'b1;
            end
          end
        end else begin
          // nearest weight; "<=" lets the later entry take a tie
          for (i = 0; i < int'(tbl_fill); i++) begin
            d = (tbl_weight[i] > w) ? tbl_weight[i] - w : w - tbl_weight[i];
            if (!have || d <= best_d) begin
              best_d = d;
              best   = i;
              have   = 1'b1;
            end
          end
        end
        if (have) begin
          rsp.found_id     = tbl_id[best];
          rsp.found_weight = tbl_weight[best];
        end else begin
          rsp.status = ST_NONE;
        end
      end
      default: ;  // MODE_NOP: plain ok, table untouched
    endcase
    op_cnt[r.mode]++;
    status_cnt[rsp.status]++;
    if (tbl_fill > peak_fill) peak_fill = tbl_fill;
    return rsp;
  endfunction

  // ---------------------------------------------------------------------------
  // Request plan. The generator keeps its own view of which ids are live so
  // that most traffic is well formed (inserts of free ids, removes of live
  // ids, queries near stored weights) and the rest is deliberate misuse.
  // ---------------------------------------------------------------------------
  planned_req_t       req_plan_q [$];
  bit [TableDepth-1:0] gen_live = '0;
  int unsigned        gen_fill = 0;
  logic [KeyBits-1:0] gen_weight [TableDepth];
  int unsigned        send_calm = 0;

  function automatic logic [IdBits-1:0] pick_id(bit want_live);
    logic [IdBits-1:0] start;
    int                k;
    start = IdBits'($urandom);
    for (k = 0; k < TableDepth; k++) begin
      if (gen_live[IdBits'(start + k)] == want_live) return IdBits'(start + k);
    end
    return start;
  endfunction

  // Weight mix: extremes, a coarse pool (many ties), near a stored weight,
  // and fully random.
  function automatic logic [KeyBits-1:0] pick_weight();
    logic [IdBits-1:0] id;
    case ($urandom_range(0, 9))
      0: return '0;
      1: return '1;
      2, 3: return KeyBits'($urandom_range(0, 15) * 16);
      4, 5: begin
        if (gen_fill == 0) return $urandom;
        id = pick_id(1'b1);
        return gen_weight[id] + KeyBits'($urandom_range(0, 4)) - KeyBits'(2);
      end
      default: return $urandom;
    endcase
  endfunction

  task automatic push_req(input mode_e op, input logic [IdBits-1:0] id,
                          input logic [KeyBits-1:0] w, input bit ex, input bit drain);
    planned_req_t item;
    item.req.mode       = op;
    item.req.node_id    = id;
    item.req.key_weight = w;
    item.req.exact      = ex;
    item.drain          = drain;
    // sender gaps 0..6, with occasional back-to-back stretches
    if (send_calm > 0) begin
      send_calm--;
      item.gap = 0;
    end else if ($urandom_range(0, 19) == 0) begin
      send_calm = $urandom_range(10, 40);
      item.gap  = 0;
    end else begin
      item.gap = $urandom_range(0, 6);
    end
    req_plan_q.push_back(item);
    if (op == MODE_INSERT && !gen_live[id] && gen_fill < TableDepth) begin
      gen_live[id]   = 1'b1;
      gen_weight[id] = w;
      gen_fill++;
    end else if (op == MODE_REMOVE && gen_live[id]) begin
      gen_live[id] = 1'b0;
      gen_fill--;
    end
  endtask

  // ---------------------------------------------------------------------------
  // Request driver: changes inputs on the falling edge only; one assignment of
  // in_valid_i per edge so back-to-back requests keep valid high.
  // ---------------------------------------------------------------------------
  int unsigned        plan_idx      = 0;
  int unsigned        gap_cnt       = 0;
  int unsigned        req_shown_cnt = 0;
  int unsigned        req_taken_cnt = 0;
  rsp_t               expected_rsp_q [$];

  always @(negedge clk_i) begin
    if (rst_ni && req_taken_cnt == req_shown_cnt) begin
      if (plan_idx < req_plan_q.size() && gap_cnt < req_plan_q[plan_idx].gap) begin
        gap_cnt++;
        in_valid_i <= 1'b0;
      end else if (plan_idx < req_plan_q.size() &&
                   !(req_plan_q[plan_idx].drain && expected_rsp_q.size() != 0)) begin
        in_req_i   <= req_plan_q[plan_idx].req;
        in_valid_i <= 1'b1;
        plan_idx++;
        req_shown_cnt++;
        gap_cnt = 0;
      end else begin
        in_valid_i <= 1'b0;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Response side: random back-pressure. The stall drawn per response counts
  // down only while a response is offered, so it really holds the block.
  // ---------------------------------------------------------------------------
  int unsigned rsp_taken_cnt = 0;
  int unsigned rsp_seen_cnt  = 0;
  int unsigned stall_cnt     = 0;
  int unsigned recv_calm     = 0;

  always @(negedge clk_i) begin
    if (rsp_seen_cnt != rsp_taken_cnt) begin
      rsp_seen_cnt = rsp_taken_cnt;
      if (recv_calm > 0) begin
        recv_calm--;
        stall_cnt = 0;
      end else if ($urandom_range(0, 15) == 0) begin
        recv_calm = $urandom_range(8, 40);
        stall_cnt = 0;
      end else begin
        stall_cnt = $urandom_range(0, 6);
      end
    end
    if (stall_cnt != 0) begin
      if (out_valid_o) stall_cnt--;
      out_ready_i <= 1'b0;
    end else begin
      out_ready_i <= 1'b1;
    end
  end

  // ---------------------------------------------------------------------------
  // Scoreboard, on the rising edge: score a taken response against the oldest
  // expectation, then log the request taken on the same edge.
  // ---------------------------------------------------------------------------
  int unsigned fail_cnt = 0;

  always @(posedge clk_i) begin
    rsp_t want;
    if (rst_ni) begin
      if (out_valid_o && out_ready_i) begin
        rsp_taken_cnt++;
        if (expected_rsp_q.size() == 0) begin
          $error("response with none outstanding: status %0d id %0d weight 0x%08h",
                 out_rsp_o.status, out_rsp_o.found_id, out_rsp_o.found_weight);
          fail_cnt++;
        end else begin
          want = expected_rsp_q.pop_front();
          if (out_rsp_o.status !== want.status) begin
            $error("status: expected %0d, got %0d", want.status, out_rsp_o.status);
            fail_cnt++;
          end
          if (out_rsp_o.found_id !== want.found_id) begin
            $error("found_id: expected %0d, got %0d", want.found_id, out_rsp_o.found_id);
            fail_cnt++;
          end
          if (out_rsp_o.found_weight !== want.found_weight) begin
            $error("found_weight: expected 0x%08h, got 0x%08h",
                   want.found_weight, out_rsp_o.found_weight);
            fail_cnt++;
          end
        end
      end
      if (in_valid_i && in_ready_o) begin
        req_taken_cnt++;
        expected_rsp_q.push_back(apply_table_op(in_req_i));
      end
    end
  end

  // Watchdog.
  int unsigned cycle_cnt = 0;

  always @(posedge clk_i) begin
    cycle_cnt++;
    if (cycle_cnt >= CycleLimit) begin
      $display("tb_sorted_best_fit_table: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus plan and end of run.
  // ---------------------------------------------------------------------------
  initial begin
    traffic_phase_e phase;
    int unsigned    phase_left;
    int unsigned    random_cnt;
    int unsigned    ins_lim;
    int unsigned    rem_lim;
    int unsigned    roll;
    bit             drain;

    // Directed: empty-table queries, absent remove, extreme ids and weights,
    // equal weights, duplicate id, exact miss, closest tie, ignored mode, and
    // removal at the front, the tail and down to empty.
    push_req(MODE_QUERY,  6'd0,  32'h0000_0000, 1'b1, 1'b0);
    push_req(MODE_QUERY,  6'd63, 32'hFFFF_FFFF, 1'b0, 1'b0);
    push_req(MODE_REMOVE, 6'd5,  32'h0000_0000, 1'b0, 1'b0);
    push_req(MODE_INSERT, 6'd0,  32'h0000_0000, 1'b0, 1'b0);
    push_req(MODE_INSERT, 6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(MODE_INSERT, 6'd10, 32'd100,       1'b0, 1'b0);
    push_req(MODE_INSERT, 6'd11, 32'd100,       1'b0, 1'b0);  // lands before id 10
    push_req(MODE_INSERT, 6'd10, 32'd7,         1'b0, 1'b0);  // duplicate
    push_req(MODE_QUERY,  6'd0,  32'd100,       1'b1, 1'b0);
    push_req(MODE_QUERY,  6'd0,  32'd101,       1'b1, 1'b0);
    push_req(MODE_QUERY,  6'd0,  32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(MODE_REMOVE, 6'd63, 32'h0000_0000, 1'b0, 1'b0);
    push_req(MODE_QUERY,  6'd0,  32'd101,       1'b1, 1'b0);  // nothing heavy enough
    push_req(MODE_INSERT, 6'd20, 32'd200,       1'b0, 1'b0);
    push_req(MODE_QUERY,  6'd0,  32'd150,       1'b0, 1'b0);  // 100 vs 200 tie
    push_req(MODE_QUERY,  6'd0,  32'h0000_0000, 1'b0, 1'b0);
    push_req(MODE_QUERY,  6'd0,  32'hFFFF_FFFF, 1'b0, 1'b0);
    push_req(MODE_QUERY,  6'd0,  32'd100,       1'b0, 1'b0);  // two exact hits
    push_req(MODE_NOP,    6'd63, 32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(MODE_REMOVE, 6'd0,  32'hFFFF_FFFF, 1'b1, 1'b0);
    push_req(MODE_REMOVE, 6'd20, 32'h0000_0000, 1'b0, 1'b0);
    push_req(MODE_REMOVE, 6'd11, 32'h0000_0000, 1'b0, 1'b0);
    push_req(MODE_REMOVE, 6'd10, 32'h0000_0000, 1'b0, 1'b0);
    push_req(MODE_QUERY,  6'd0,  32'd100,       1'b0, 1'b0);

    // Random: phases that grow, shrink or churn the table.
    phase      = PH_MIX;
    phase_left = 0;
    random_cnt = 0;
    while (random_cnt < RandomItems) begin
      if (phase_left == 0) begin
        phase      = traffic_phase_e'($urandom_range(0, 2));
        phase_left = $urandom_range(20, 120);
      end
      phase_left--;
      case (phase)
        PH_FILL:  begin ins_lim = 72; rem_lim = 82; end
        PH_DRAIN: begin ins_lim = 15; rem_lim = 75; end
        default:  begin ins_lim = 35; rem_lim = 65; end
      endcase
      // the first random request waits for the directed part to drain
      drain = (random_cnt == 0) || ($urandom_range(0, 99) == 0);
      if ($urandom_range(0, 99) < 2) begin
        push_req(MODE_NOP, IdBits'($urandom), $urandom, 1'($urandom), drain);
      end else begin
        random_cnt++;
        roll = $urandom_range(0, 99);
        if (roll < ins_lim) begin
          push_req(MODE_INSERT,
                   ($urandom_range(0, 4) != 0) ? pick_id(1'b0) : IdBits'($urandom),
                   pick_weight(), 1'($urandom), drain);
        end else if (roll < rem_lim) begin
          push_req(MODE_REMOVE,
                   ($urandom_range(0, 4) != 0) ? pick_id(1'b1) : IdBits'($urandom),
                   $urandom, 1'($urandom), drain);
        end else begin
          push_req(MODE_QUERY, IdBits'($urandom), pick_weight(), 1'($urandom), drain);
        end
      end
    end

    repeat (9) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    // all requests out and taken, every response back, then a quiet tail
    while (plan_idx < req_plan_q.size() || req_taken_cnt != req_shown_cnt ||
           expected_rsp_q.size() != 0) begin
      @(posedge clk_i);
    end
    repeat (SettleCycles) @(posedge clk_i);

    $display("run: %0d inserts, %0d removes, %0d queries, %0d ignored; peak fill %0d/%0d",
             op_cnt[MODE_INSERT], op_cnt[MODE_REMOVE], op_cnt[MODE_QUERY],
             op_cnt[MODE_NOP], peak_fill, TableDepth);
    $display("outcomes: ok %0d, full %0d, none %0d, duplicate %0d; %0d cycles",
             status_cnt[ST_OK], status_cnt[ST_FULL], status_cnt[ST_NONE],
             status_cnt[ST_DUP], cycle_cnt);
    if (fail_cnt == 0) begin
      $display("tb_sorted_best_fit_table: PASS");
    end else begin
      $display("tb_sorted_best_fit_table: FAIL");
    end
    $finish;
  end

endmodule
